### rtl/mstp_pkg.sv
// Shared constants, types and register codes of the motion skin tint pixel block.
package mstp_pkg;

    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;
    localparam int FRAC_BITS  = 8;

    localparam int NPIX   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);

    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int PIX_W  = 8;
    localparam int MEAN_W = PIX_W + FRAC_BITS;
    localparam int HOLD_W = 8;
    localparam int LIM_W  = 16;
    localparam int STEP_W = 8;
    localparam int SQ_W   = 2 * MEAN_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_STEP    = 3'd4;

    localparam logic [X_W-1:0]    RST_FRAME_WIDTH  = 10'd640;
    localparam logic [Y_W-1:0]    RST_FRAME_HEIGHT = 9'd480;
    localparam logic [LIM_W-1:0]  RST_DIFF_LIMIT   = 16'd50;
    localparam logic [HOLD_W-1:0] RST_HOLD_FRAMES  = 8'd1;
    localparam logic [STEP_W-1:0] RST_TINT_STEP    = 8'd10;

    localparam logic [MEAN_W-1:0] RST_MEAN = MEAN_W'(128) << FRAC_BITS;

    // Gray is the channel sum divided by three, done as a multiply by 683 / 2048.
    localparam int SUM_W      = PIX_W + 2;
    localparam int GRAY_SHIFT = 11;
    localparam int PROD_W     = SUM_W + GRAY_SHIFT - 1;
    localparam logic [PROD_W-1:0] GRAY_RECIP = PROD_W'(683);

    localparam logic [PIX_W-1:0] SKIN_RED_MIN   = 8'd95;
    localparam logic [PIX_W-1:0] SKIN_GREEN_MIN = 8'd40;
    localparam logic [PIX_W-1:0] SKIN_BLUE_MIN  = 8'd20;
    localparam logic [PIX_W-1:0] SKIN_SPREAD    = 8'd15;
    localparam logic [PIX_W-1:0] TINT_BLUE      = 8'd255;

    typedef struct packed {
        logic [X_W-1:0]    frame_width;
        logic [Y_W-1:0]    frame_height;
        logic [LIM_W-1:0]  diff_limit;
        logic [HOLD_W-1:0] hold_frames;
        logic [STEP_W-1:0] tint_step;
    } cfg_t;

    typedef struct packed {
        logic              mask;
        logic [HOLD_W-1:0] hold;
        logic [MEAN_W-1:0] mean;
    } entry_t;

    localparam int ENTRY_W = 1 + HOLD_W + MEAN_W;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

endpackage

### rtl/mstp_state_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module mstp_state_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/mstp_cfg_regs.sv
// Configuration registers with their reset values and a plain write port.
module mstp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mstp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mstp_pkg::cfg_t                     cfg
);

    mstp_pkg::cfg_t cfg_reg;
    mstp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                mstp_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_data[mstp_pkg::X_W-1:0];
                mstp_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_data[mstp_pkg::Y_W-1:0];
                mstp_pkg::REG_DIFF_LIMIT:
                    cfg_next.diff_limit = cfg_data[mstp_pkg::LIM_W-1:0];
                mstp_pkg::REG_HOLD_FRAMES:
                    cfg_next.hold_frames = cfg_data[mstp_pkg::HOLD_W-1:0];
                mstp_pkg::REG_TINT_STEP:
                    cfg_next.tint_step = cfg_data[mstp_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= mstp_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= mstp_pkg::RST_FRAME_HEIGHT;
            cfg_reg.diff_limit   <= mstp_pkg::RST_DIFF_LIMIT;
            cfg_reg.hold_frames  <= mstp_pkg::RST_HOLD_FRAMES;
            cfg_reg.tint_step    <= mstp_pkg::RST_TINT_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mstp_clear_seq.sv
// Sweep that writes the reset entry into every pixel location after reset.
module mstp_clear_seq (
    input  logic              clk,
    input  logic              rst_n,
    output logic              busy,
    output mstp_pkg::mem_wr_t wr_req
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [mstp_pkg::ADDR_W-1:0] addr_reg;
    logic [mstp_pkg::ADDR_W-1:0] addr_next;
    logic                        last;

    assign last = (addr_reg == mstp_pkg::ADDR_W'(mstp_pkg::NPIX - 1));

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + mstp_pkg::ADDR_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy           = busy_reg;
    assign wr_req.en        = busy_reg;
    assign wr_req.addr      = addr_reg;
    assign wr_req.data.mask = 1'b1;
    assign wr_req.data.hold = '0;
    assign wr_req.data.mean = mstp_pkg::RST_MEAN;

`ifndef SYNTHESIS
    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && $past(busy_reg) && $past(rst_n))
        |-> (addr_reg == $past(addr_reg) + mstp_pkg::ADDR_W'(1)))
        else $error("Clearing sweep skipped or repeated an address.");
`endif

endmodule

### rtl/mstp_pixel_pipe.sv
// Three-stage pixel pipeline: state read, mean update, mask update with tint and output.
module mstp_pixel_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mstp_pkg::cfg_t                cfg,
    input  logic                          clearing,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mstp_pkg::X_W-1:0]      x_pos,
    input  logic [mstp_pkg::Y_W-1:0]      y_pos,
    input  logic [mstp_pkg::PIX_W-1:0]    blue_in,
    input  logic [mstp_pkg::PIX_W-1:0]    green_in,
    input  logic [mstp_pkg::PIX_W-1:0]    red_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mstp_pkg::PIX_W-1:0]    blue_out,
    output logic [mstp_pkg::PIX_W-1:0]    green_out,
    output logic [mstp_pkg::PIX_W-1:0]    red_out,
    output logic                          moving,
    output logic                          skin,
    output mstp_pkg::mem_rd_t             rd_req,
    input  mstp_pkg::entry_t              rd_data,
    output mstp_pkg::mem_wr_t             wr_req
);

    localparam int W = mstp_pkg::PIX_W;

    logic                          adv;
    logic                          accept;
    logic                          in_range_in;
    logic                          border_in;
    logic [mstp_pkg::ADDR_W-1:0]   addr_in;
    logic [mstp_pkg::SUM_W-1:0]    sum_in;
    logic [mstp_pkg::PROD_W-1:0]   prod_in;
    logic [W-1:0]                  gray_in;

    logic                          a_valid_reg;
    logic [mstp_pkg::ADDR_W-1:0]   a_addr_reg;
    logic                          a_in_range_reg;
    logic                          a_border_reg;
    logic [W-1:0]                  a_blue_reg;
    logic [W-1:0]                  a_green_reg;
    logic [W-1:0]                  a_red_reg;
    logic [W-1:0]                  a_gray_reg;

    logic                          a_fwd_b;
    logic                          a_fwd_w;
    logic [mstp_pkg::MEAN_W-1:0]   a_mean;
    logic [mstp_pkg::HOLD_W-1:0]   a_hold;
    logic                          a_mask;
    logic [mstp_pkg::MEAN_W-1:0]   a_gray_fx;
    logic [mstp_pkg::MEAN_W-1:0]   a_diff;
    logic [mstp_pkg::MEAN_W:0]     a_mean_sum;
    logic [W-1:0]                  a_max;
    logic [W-1:0]                  a_min;
    logic [W-1:0]                  a_gap;
    logic                          a_skin_test;
    logic                          a_skin;

    logic                          b_valid_reg;
    logic [mstp_pkg::ADDR_W-1:0]   b_addr_reg;
    logic                          b_in_range_reg;
    logic                          b_skin_reg;
    logic [W-1:0]                  b_blue_reg;
    logic [W-1:0]                  b_green_reg;
    logic [W-1:0]                  b_red_reg;
    logic [mstp_pkg::MEAN_W-1:0]   b_diff_reg;
    logic [mstp_pkg::MEAN_W-1:0]   b_mean_reg;
    logic [mstp_pkg::HOLD_W-1:0]   b_hold_reg;
    logic                          b_mask_reg;

    logic                          b_fwd_w;
    logic [mstp_pkg::HOLD_W-1:0]   b_hold_old;
    logic                          b_mask_old;
    logic [mstp_pkg::SQ_W-1:0]     b_sq;
    logic [mstp_pkg::SQ_W-1:0]     b_lim;
    logic                          b_still;
    logic [mstp_pkg::HOLD_W-1:0]   b_hold_new;
    logic                          b_mask_new;
    logic                          b_moving;
    logic                          b_tint;

    logic                          out_valid_reg;
    logic [W-1:0]                  blue_out_reg;
    logic [W-1:0]                  green_out_reg;
    logic [W-1:0]                  red_out_reg;
    logic                          moving_reg;
    logic                          skin_reg;

    logic                          wh_valid_reg;
    logic [mstp_pkg::ADDR_W-1:0]   wh_addr_reg;
    mstp_pkg::entry_t              wh_data_reg;

    // The whole pipeline moves together whenever the output register is empty or being taken.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !clearing;
    assign accept   = in_valid && in_ready;

    assign in_range_in = (32'(x_pos) < mstp_pkg::MAX_WIDTH)
                       && (32'(y_pos) < mstp_pkg::MAX_HEIGHT);
    assign addr_in     = mstp_pkg::ADDR_W'(y_pos) * mstp_pkg::ADDR_W'(mstp_pkg::MAX_WIDTH)
                       + mstp_pkg::ADDR_W'(x_pos);
    assign border_in   = (x_pos == '0) || (y_pos == '0)
                       || ((11'(x_pos) + 11'd1) >= 11'(cfg.frame_width))
                       || ((10'(y_pos) + 10'd1) >= 10'(cfg.frame_height))
                       || !in_range_in;

    assign sum_in  = mstp_pkg::SUM_W'(blue_in) + mstp_pkg::SUM_W'(green_in)
                   + mstp_pkg::SUM_W'(red_in);
    assign prod_in = mstp_pkg::PROD_W'(sum_in) * mstp_pkg::GRAY_RECIP;
    assign gray_in = prod_in[mstp_pkg::GRAY_SHIFT +: W];

    assign rd_req.en   = accept && in_range_in;
    assign rd_req.addr = addr_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            wh_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
            wh_valid_reg  <= wr_req.en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_addr_reg     <= addr_in;
            a_in_range_reg <= in_range_in;
            a_border_reg   <= border_in;
            a_blue_reg     <= blue_in;
            a_green_reg    <= green_in;
            a_red_reg      <= red_in;
            a_gray_reg     <= gray_in;
        end
    end

    // The memory read missed the write made at the same edge and the one still in the mask stage.
    assign a_fwd_b = b_valid_reg && b_in_range_reg && (b_addr_reg == a_addr_reg);
    assign a_fwd_w = wh_valid_reg && (wh_addr_reg == a_addr_reg);

    always_comb
    begin
        priority if (a_fwd_b)
        begin
            a_mean = b_mean_reg;
        end
        else if (a_fwd_w)
        begin
            a_mean = wh_data_reg.mean;
        end
        else
        begin
            a_mean = rd_data.mean;
        end
    end

    assign a_hold = a_fwd_w ? wh_data_reg.hold : rd_data.hold;
    assign a_mask = a_fwd_w ? wh_data_reg.mask : rd_data.mask;

    assign a_gray_fx  = mstp_pkg::MEAN_W'(a_gray_reg) << mstp_pkg::FRAC_BITS;
    assign a_diff     = (a_mean >= a_gray_fx) ? (a_mean - a_gray_fx) : (a_gray_fx - a_mean);
    assign a_mean_sum = (mstp_pkg::MEAN_W + 1)'(a_mean) + (mstp_pkg::MEAN_W + 1)'(a_gray_fx);

    always_comb
    begin
        a_max = a_red_reg;
        if (a_green_reg > a_max)
        begin
            a_max = a_green_reg;
        end
        if (a_blue_reg > a_max)
        begin
            a_max = a_blue_reg;
        end
        a_min = a_red_reg;
        if (a_green_reg < a_min)
        begin
            a_min = a_green_reg;
        end
        if (a_blue_reg < a_min)
        begin
            a_min = a_blue_reg;
        end
    end

    assign a_gap = (a_red_reg > a_green_reg) ? (a_red_reg - a_green_reg)
                                             : (a_green_reg - a_red_reg);
    assign a_skin_test = (a_red_reg > mstp_pkg::SKIN_RED_MIN)
                      && (a_green_reg > mstp_pkg::SKIN_GREEN_MIN)
                      && (a_blue_reg > mstp_pkg::SKIN_BLUE_MIN)
                      && ((a_max - a_min) > mstp_pkg::SKIN_SPREAD)
                      && (a_gap > mstp_pkg::SKIN_SPREAD)
                      && (a_red_reg > a_green_reg)
                      && (a_red_reg > a_blue_reg);
    assign a_skin = a_border_reg || a_skin_test;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_addr_reg     <= a_addr_reg;
            b_in_range_reg <= a_in_range_reg;
            b_skin_reg     <= a_skin;
            b_blue_reg     <= a_blue_reg;
            b_green_reg    <= a_green_reg;
            b_red_reg      <= a_red_reg;
            b_diff_reg     <= a_diff;
            b_mean_reg     <= a_mean_sum[mstp_pkg::MEAN_W:1];
            b_hold_reg     <= a_hold;
            b_mask_reg     <= a_mask;
        end
    end

    // The previous item's mask and counter are only final at the edge that moved this one here.
    assign b_fwd_w    = wh_valid_reg && (wh_addr_reg == b_addr_reg);
    assign b_hold_old = b_fwd_w ? wh_data_reg.hold : b_hold_reg;
    assign b_mask_old = b_fwd_w ? wh_data_reg.mask : b_mask_reg;

    assign b_sq    = mstp_pkg::SQ_W'(b_diff_reg) * mstp_pkg::SQ_W'(b_diff_reg);
    assign b_lim   = mstp_pkg::SQ_W'(cfg.diff_limit) << (2 * mstp_pkg::FRAC_BITS);
    assign b_still = (b_sq <= b_lim);

    always_comb
    begin
        b_hold_new = b_hold_old;
        b_mask_new = b_mask_old;
        if (!b_still)
        begin
            b_mask_new = 1'b1;
            b_hold_new = cfg.hold_frames;
        end
        else if (b_hold_old == '0)
        begin
            b_mask_new = 1'b0;
        end
        else
        begin
            b_hold_new = b_hold_old - mstp_pkg::HOLD_W'(1);
        end
    end

    assign b_moving = b_in_range_reg && b_mask_new;
    assign b_tint   = b_moving && !b_skin_reg;

    assign wr_req.en        = adv && b_valid_reg && b_in_range_reg;
    assign wr_req.addr      = b_addr_reg;
    assign wr_req.data.mask = b_mask_new;
    assign wr_req.data.hold = b_hold_new;
    assign wr_req.data.mean = b_mean_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wh_addr_reg   <= wr_req.addr;
            wh_data_reg   <= wr_req.data;
            blue_out_reg  <= b_tint ? mstp_pkg::TINT_BLUE : b_blue_reg;
            green_out_reg <= b_tint ? (b_green_reg + cfg.tint_step) : b_green_reg;
            red_out_reg   <= b_tint ? (b_red_reg + cfg.tint_step) : b_red_reg;
            moving_reg    <= b_moving;
            skin_reg      <= b_skin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign blue_out  = blue_out_reg;
    assign green_out = green_out_reg;
    assign red_out   = red_out_reg;
    assign moving    = moving_reg;
    assign skin      = skin_reg;

`ifndef SYNTHESIS
    a_fwd_reaches_b: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && wr_req.en && a_valid_reg && a_in_range_reg && (a_addr_reg == wr_req.addr))
        |=> (wh_valid_reg && (wh_addr_reg == b_addr_reg) && b_valid_reg))
        else $error("Write to a pixel is not visible to the next request for it.");
    a_tint_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && moving_reg && !skin_reg) |-> (blue_out_reg == mstp_pkg::TINT_BLUE))
        else $error("Tinted pixel left without full blue.");
    a_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!a_valid_reg && !b_valid_reg && !wr_req.en))
        else $error("Pipeline active during the clearing sweep.");
`endif

endmodule

### rtl/motion_skin_tint_pixel.sv
// Top level of the motion skin tint pixel block.
//
// Each request is one BGR pixel with its column and line. The block keeps a running gray
// mean, a hold counter and a motion mask per pixel location in one 307200-entry memory and
// tints moving, non-skin pixels off the frame border. It takes one request per clock while the
// output is not stalled; the pipeline reads the pixel's entry at acceptance, updates the mean
// in the read stage and the mask and counter in the following stage, and registers the result
// at the output, writing back while forwarding covers repeated requests to the same pixel.
// After reset the block writes the initial entry into every location, one a cycle, and takes
// no request until that sweep ends; configuration writes are taken at once.
module motion_skin_tint_pixel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mstp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mstp_pkg::X_W-1:0]           x_pos,
    input  logic [mstp_pkg::Y_W-1:0]           y_pos,
    input  logic [mstp_pkg::PIX_W-1:0]         blue_in,
    input  logic [mstp_pkg::PIX_W-1:0]         green_in,
    input  logic [mstp_pkg::PIX_W-1:0]         red_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mstp_pkg::PIX_W-1:0]         blue_out,
    output logic [mstp_pkg::PIX_W-1:0]         green_out,
    output logic [mstp_pkg::PIX_W-1:0]         red_out,
    output logic                               moving,
    output logic                               skin
);

    mstp_pkg::cfg_t    cfg;
    logic              clearing;
    mstp_pkg::mem_wr_t clr_wr;
    mstp_pkg::mem_wr_t pipe_wr;
    mstp_pkg::mem_wr_t ram_wr;
    mstp_pkg::mem_rd_t rd_req;
    mstp_pkg::entry_t  rd_data;

    mstp_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    mstp_clear_seq u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .busy   (clearing),
        .wr_req (clr_wr)
    );

    assign ram_wr = clearing ? clr_wr : pipe_wr;

    mstp_state_ram #(
        .DEPTH  (mstp_pkg::NPIX),
        .DATA_W (mstp_pkg::ENTRY_W),
        .ADDR_W (mstp_pkg::ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_req.en),
        .rd_addr (rd_req.addr),
        .rd_data (rd_data)
    );

    mstp_pixel_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clearing  (clearing),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .moving    (moving),
        .skin      (skin),
        .rd_req    (rd_req),
        .rd_data   (rd_data),
        .wr_req    (pipe_wr)
    );

endmodule
